// File: rtl/skf_pkg.sv
package skf_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // register file layout
    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INIT_EST   = 3'd0,
        REG_INIT_VAR   = 3'd1,
        REG_STEP       = 3'd2,
        REG_PROC_NOISE = 3'd3,
        REG_MEAS_NOISE = 3'd4
    } reg_idx_t;

    // reset values, truncated to the word width where used
    localparam logic [63:0] RST_INIT_EST   = 64'd0;
    localparam logic [63:0] RST_INIT_VAR   = 64'd65536;
    localparam logic [63:0] RST_STEP       = 64'd0;
    localparam logic [63:0] RST_PROC_NOISE = 64'd0;
    localparam logic [63:0] RST_MEAS_NOISE = 64'd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREDICT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_EST,
        ST_MUL_VAR,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/skf_cfg.sv
module skf_cfg
    import skf_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    localparam int APB_DW    = (WORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB  = (WORD_WIDTH > 32) ? 3 : 2,
    localparam int APB_AW    = ADDR_LSB + REG_IDX_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output logic [WORD_WIDTH-1:0] init_est,
    output logic [WORD_WIDTH-1:0] init_var,
    output logic [WORD_WIDTH-1:0] step_offset,
    output logic [WORD_WIDTH-1:0] proc_noise,
    output logic [WORD_WIDTH-1:0] meas_noise
);

    logic [WORD_WIDTH-1:0] init_est_reg;
    logic [WORD_WIDTH-1:0] init_var_reg;
    logic [WORD_WIDTH-1:0] step_reg;
    logic [WORD_WIDTH-1:0] proc_noise_reg;
    logic [WORD_WIDTH-1:0] meas_noise_reg;
    reg_idx_t              idx;
    logic                  wr_en;
    logic [WORD_WIDTH-1:0] rd_word;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:ADDR_LSB]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_est_reg   <= RST_INIT_EST[WORD_WIDTH-1:0];
            init_var_reg   <= RST_INIT_VAR[WORD_WIDTH-1:0];
            step_reg       <= RST_STEP[WORD_WIDTH-1:0];
            proc_noise_reg <= RST_PROC_NOISE[WORD_WIDTH-1:0];
            meas_noise_reg <= RST_MEAS_NOISE[WORD_WIDTH-1:0];
        end else if (wr_en) begin
            unique case (idx)
                REG_INIT_EST:   init_est_reg   <= pwdata[WORD_WIDTH-1:0];
                REG_INIT_VAR:   init_var_reg   <= pwdata[WORD_WIDTH-1:0];
                REG_STEP:       step_reg       <= pwdata[WORD_WIDTH-1:0];
                REG_PROC_NOISE: proc_noise_reg <= pwdata[WORD_WIDTH-1:0];
                REG_MEAS_NOISE: meas_noise_reg <= pwdata[WORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INIT_EST:   rd_word = init_est_reg;
            REG_INIT_VAR:   rd_word = init_var_reg;
            REG_STEP:       rd_word = step_reg;
            REG_PROC_NOISE: rd_word = proc_noise_reg;
            REG_MEAS_NOISE: rd_word = meas_noise_reg;
            default:        rd_word = '0;
        endcase
    end

    assign prdata      = APB_DW'(rd_word);
    assign init_est    = init_est_reg;
    assign init_var    = init_var_reg;
    assign step_offset = step_reg;
    assign proc_noise  = proc_noise_reg;
    assign meas_noise  = meas_noise_reg;

endmodule

// File: rtl/skf_div.sv
// Serial gain divider: floor(p * 2^F / (p + r)), one quotient bit per cycle.
module skf_div #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int CNT_W     = $clog2(FRAC_BITS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic [WORD_WIDTH-1:0] num,
    input  logic [WORD_WIDTH-1:0] noise,
    output logic                  done,
    output logic [FRAC_BITS:0]    gain
);

    localparam logic [FRAC_BITS:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [WORD_WIDTH:0]   rem_reg, rem_next;
    logic [WORD_WIDTH:0]   den_reg;
    logic [FRAC_BITS:0]    quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [WORD_WIDTH+1:0] trial;
    logic [WORD_WIDTH+1:0] diff;
    logic                  fits;

    // remainder stays below the divisor, so both branches fit W+1 bits
    assign trial    = {rem_reg, 1'b0};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[WORD_WIDTH:0] : trial[WORD_WIDTH:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                rem_reg <= {1'b0, num};
                den_reg <= {1'b0, num} + {1'b0, noise};
                cnt_reg <= CNT_W'(FRAC_BITS);
                quo_reg <= '0;
                if (num == '0) begin
                    done_reg <= 1'b1;
                end else if (noise == '0) begin
                    quo_reg  <= GAIN_ONE;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[FRAC_BITS-1:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign gain = quo_reg;

endmodule

// File: rtl/skf_mulr.sv
// Shared multiplier: (a * b + 2^(F-1)) >> F, registered.
module skf_mulr #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic [FRAC_BITS:0]    a,
    input  logic [WORD_WIDTH-1:0] b,
    output logic [WORD_WIDTH-1:0] q
);

    localparam int PW = WORD_WIDTH + FRAC_BITS + 1;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic [PW-1:0]         prod;
    logic [PW-1:0]         rnd;
    logic [WORD_WIDTH-1:0] q_reg;

    assign prod = PW'(a) * PW'(b);
    assign rnd  = prod + HALF;

    // callers only use products that fit the word after scaling
    always_ff @(posedge aclk) begin
        q_reg <= rnd[WORD_WIDTH+FRAC_BITS-1:FRAC_BITS];
    end

    assign q = q_reg;

endmodule

// File: rtl/scalar_kalman_filter.sv
// Channel   | Dir | Ports                         | Contents
// ----------+-----+-------------------------------+----------------------------------
// input     | in  | s_tvalid s_tready s_tdata     | measurement (signed QW-F.F)
//           |     | s_tuser                       | start_req
// result    | out | m_tvalid m_tready m_tdata     | estimate, variance
// config    | in  | psel penable pwrite paddr ... | five W-bit registers, APB
//
// Sequence: accept in IDLE, then PREDICT, DIV_GO, DIV_WAIT until the serial gain divider is done
//   (it skips its bit loop when P or R is zero), MUL_EST, MUL_VAR, FINISH; the next item is taken back in IDLE.
// Reset: synchronous, active low; estimate and variance go to zero, registers
//   to their reset values.
// Stalls: a finished result sits in the output register; the next item is
//   accepted meanwhile and only its final write waits for that register.
module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_DW     = ((WORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW    = ((2 * WORD_WIDTH + 7) / 8) * 8,
    localparam int APB_DW    = (WORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB  = (WORD_WIDTH > 32) ? 3 : 2,
    localparam int APB_AW    = ADDR_LSB + REG_IDX_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_DW-1:0]  s_tdata,   // [W-1:0] measurement, rest pad
    input  logic              s_tuser,   // [0] start_req
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_DW-1:0] m_tdata,   // [W-1:0] estimate, [2W-1:W] variance
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [FRAC_BITS:0]    GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [WORD_WIDTH-1:0] S_MAX    = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] S_MIN    = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    // configuration values
    logic [WORD_WIDTH-1:0] cfg_init_est, cfg_init_var, cfg_step, cfg_q, cfg_r;

    state_t state_reg, state_next;

    // item and filter state
    logic [WORD_WIDTH-1:0] z_reg;
    logic                  start_reg;
    logic [WORD_WIDTH-1:0] est_reg, var_reg;
    logic [WORD_WIDTH-1:0] xp_reg, xp_next;   // predicted estimate
    logic [WORD_WIDTH-1:0] pp_reg, pp_next;   // predicted variance
    logic [WORD_WIDTH-1:0] mag_reg, mag_next; // |z - xp|
    logic                  up_reg, up_next;   // z >= xp
    logic [WORD_WIDTH-1:0] est_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [WORD_WIDTH-1:0] out_est_reg, out_var_reg;

    // control
    logic in_fire, pred_load, div_go, mag_load, est_load, out_load, sel_var;

    // shared units
    logic                  div_done;
    logic [FRAC_BITS:0]    gain;
    logic [FRAC_BITS:0]    mul_a;
    logic [WORD_WIDTH-1:0] mul_b, mul_q;

    // predict path
    logic [WORD_WIDTH-1:0] base_est, base_var, sum_s;
    logic [WORD_WIDTH:0]   sum_u;
    logic                  s_ovf;

    skf_cfg #(.WORD_WIDTH(WORD_WIDTH)) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .init_est    (cfg_init_est),
        .init_var    (cfg_init_var),
        .step_offset (cfg_step),
        .proc_noise  (cfg_q),
        .meas_noise  (cfg_r)
    );

    skf_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (div_go),
        .num     (pp_reg),
        .noise   (cfg_r),
        .done    (div_done),
        .gain    (gain)
    );

    skf_mulr #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .q    (mul_q)
    );

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_PREDICT;
            ST_PREDICT:  state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (div_done) state_next = ST_MUL_EST;
            ST_MUL_EST:  state_next = ST_MUL_VAR;
            ST_MUL_VAR:  state_next = ST_FINISH;
            ST_FINISH:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---- control outputs ----
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        pred_load = (state_reg == ST_PREDICT);
        div_go    = (state_reg == ST_DIV_GO);
        mag_load  = (state_reg == ST_DIV_GO);
        est_load  = (state_reg == ST_MUL_VAR);
        // keep the variance product on the multiplier while the result stalls
        sel_var   = (state_reg == ST_MUL_VAR) || (state_reg == ST_FINISH);
        out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    end

    assign in_fire = s_tvalid && s_tready;

    // ---- datapath ----
    // predict: saturating adds, with start reloading the prior
    assign base_est = start_reg ? cfg_init_est : est_reg;
    assign base_var = start_reg ? cfg_init_var : var_reg;
    assign sum_s    = base_est + cfg_step;
    assign s_ovf    = (base_est[WORD_WIDTH-1] == cfg_step[WORD_WIDTH-1]) &&
                      (sum_s[WORD_WIDTH-1] != base_est[WORD_WIDTH-1]);
    assign xp_next  = s_ovf ? (base_est[WORD_WIDTH-1] ? S_MIN : S_MAX) : sum_s;
    assign sum_u    = {1'b0, base_var} + {1'b0, cfg_q};
    assign pp_next  = sum_u[WORD_WIDTH] ? '1 : sum_u[WORD_WIDTH-1:0];

    // residual sign and magnitude
    assign up_next  = $signed(z_reg) >= $signed(xp_reg);
    assign mag_next = up_next ? (z_reg - xp_reg) : (xp_reg - z_reg);

    // correction lies between xp and z, no overflow possible
    assign est_next = up_reg ? (xp_reg + mul_q) : (xp_reg - mul_q);

    assign mul_a = sel_var ? (GAIN_ONE - gain) : gain;
    assign mul_b = sel_var ? pp_reg : mag_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            est_reg     <= '0;
            var_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (est_load) est_reg <= est_next;
            if (out_load) var_reg <= mul_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            z_reg     <= s_tdata[WORD_WIDTH-1:0];
            start_reg <= s_tuser;
        end
        if (pred_load) begin
            xp_reg <= xp_next;
            pp_reg <= pp_next;
        end
        if (mag_load) begin
            mag_reg <= mag_next;
            up_reg  <= up_next;
        end
        if (out_load) begin
            out_est_reg <= est_reg;
            out_var_reg <= mul_q;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DW'({out_var_reg, out_est_reg});

`ifndef ASSERT_OFF
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the gain wait");

    a_gain_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (gain <= GAIN_ONE))
        else $error("gain above one");

    a_var_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (mul_q <= pp_reg))
        else $error("posterior variance above prior");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_PREDICT))
        else $error("accepted item did not start predict");
`endif

endmodule

// File: test/scalar_kalman_filter_tb.sv
`timescale 1ns / 100ps

module scalar_kalman_filter_tb
    import skf_pkg::*;
();

    // cycles with no accepted item, result or register write before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // settle time after the last result
    localparam int DRAIN_CYCLES   = 60;
    localparam int ITEMS_PER_SET  = 52;

    typedef struct packed {
        logic [31:0] z;
        logic        start;
    } meas_item_t;

    typedef struct packed {
        logic [31:0] estimate;
        logic [31:0] variance;
    } posterior_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] measurement
    logic        s_tuser  = 1'b0;  // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] estimate, [63:32] variance
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    scalar_kalman_filter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and of the filter state
    // ------------------------------------------------------------------
    logic [31:0] cfg_init_est   = RST_INIT_EST[31:0];
    logic [31:0] cfg_init_var   = RST_INIT_VAR[31:0];
    logic [31:0] cfg_offset     = RST_STEP[31:0];
    logic [31:0] cfg_proc_noise = RST_PROC_NOISE[31:0];
    logic [31:0] cfg_meas_noise = RST_MEAS_NOISE[31:0];
    logic [31:0] est_q16 = '0;   // signed Q16.16 posterior estimate
    logic [31:0] var_q16 = '0;   // unsigned Q16.16 posterior variance

    meas_item_t  meas_q[$];       // items waiting for the driver
    posterior_t  posterior_q[$];  // predicted results, oldest first
    meas_item_t  next_item;
    posterior_t  want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles    = 0;

    // One predict + update step; advances the predictor state.
    function automatic posterior_t kf_step(input logic [31:0] z, input logic start);
        logic [32:0] xsum;
        logic [32:0] psum;
        logic [31:0] xp, pp, mag, corr;
        logic [63:0] denom, gain_k, prod;
        posterior_t  res;
        if (start) begin
            est_q16 = cfg_init_est;
            var_q16 = cfg_init_var;
        end
        // predict, both sums saturate
        xsum = {est_q16[31], est_q16} + {cfg_offset[31], cfg_offset};
        if (xsum[32] != xsum[31])
            xp = xsum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            xp = xsum[31:0];
        psum = {1'b0, var_q16} + {1'b0, cfg_proc_noise};
        pp = psum[32] ? 32'hffff_ffff : psum[31:0];
        // gain in Q1.16, zero when P+R is zero
        denom = {32'd0, pp} + {32'd0, cfg_meas_noise};
        gain_k = (denom == 64'd0) ? 64'd0 : ({32'd0, pp} << 16) / denom;
        // correction on the residual magnitude, ties away from zero
        if ($signed(z) >= $signed(xp)) begin
            mag = z - xp;
            prod = gain_k * {32'd0, mag} + 64'd32768;
            corr = prod[47:16];
            est_q16 = xp + corr;
        end else begin
            mag = xp - z;
            prod = gain_k * {32'd0, mag} + 64'd32768;
            corr = prod[47:16];
            est_q16 = xp - corr;
        end
        // (1 - K) * P, ties up
        prod = (64'd65536 - gain_k) * {32'd0, pp} + 64'd32768;
        var_q16 = prod[47:16];
        res.estimate = est_q16;
        res.variance = var_q16;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued items, random gaps while idle
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                posterior_q.insert(posterior_q.size(), kf_step(s_tdata, s_tuser));
            if (!s_tvalid || s_tready) begin
                if (meas_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = meas_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.z;
                    s_tuser  <= next_item.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (posterior_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: estimate %h variance %h",
                                 m_tdata[31:0], m_tdata[63:32]);
                end else begin
                    want = posterior_q.pop_front();
                    if (m_tdata[31:0] !== want.estimate) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("estimate mismatch: expected %h got %h",
                                     want.estimate, m_tdata[31:0]);
                    end
                    if (m_tdata[63:32] !== want.variance) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("variance mismatch: expected %h got %h",
                                     want.variance, m_tdata[63:32]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any accepted item, result or register write restarts the count
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("scalar_kalman_filter_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [31:0] z, input logic start);
        meas_item_t it;
        it.z = z;
        it.start = start;
        meas_q.insert(meas_q.size(), it);
    endtask

    // wait until every queued item went in and every result came out
    task automatic wait_idle();
        while (meas_q.size() != 0 || s_tvalid || posterior_q.size() != 0)
            @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; register lands on the access edge
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_INIT_EST:   cfg_init_est   = value;
            REG_INIT_VAR:   cfg_init_var   = value;
            REG_STEP:       cfg_offset     = value;
            REG_PROC_NOISE: cfg_proc_noise = value;
            REG_MEAS_NOISE: cfg_meas_noise = value;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_all(input logic [31:0] ie, input logic [31:0] iv,
                           input logic [31:0] so, input logic [31:0] pn,
                           input logic [31:0] mn);
        cfg_write(REG_INIT_EST, ie);
        cfg_write(REG_INIT_VAR, iv);
        cfg_write(REG_STEP, so);
        cfg_write(REG_PROC_NOISE, pn);
        cfg_write(REG_MEAS_NOISE, mn);
    endtask

    // register value: extremes now and then, mostly plausible Q16.16 magnitudes
    function automatic logic [31:0] pick_word(input bit signed_fmt);
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'h0;
            1:       w = signed_fmt ? 32'h7fff_ffff : 32'hffff_ffff;
            2:       w = signed_fmt ? 32'h8000_0000 : 32'h1;
            3, 4:    w = $urandom;
            default: w = signed_fmt ? $urandom_range(0, 32'h40000) - 32'h20000
                                    : $urandom_range(0, 32'h40000);
        endcase
        return w;
    endfunction

    // A tracking run: mostly starts with a reload, then noisy samples around
    // a drifting position; a few wild samples and stray reloads mixed in.
    task automatic add_run(input int n);
        logic [31:0] base;
        logic [31:0] z;
        logic        start;
        int          i;
        base = ($urandom_range(0, 3) == 0) ? $urandom
                                           : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        for (i = 0; i < n; i++) begin
            if (i == 0)
                start = ($urandom_range(0, 4) != 0);
            else
                start = ($urandom_range(0, 29) == 0);
            case ($urandom_range(0, 9))
                0:       z = $urandom;
                1:       z = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
                default: z = base + $urandom_range(0, 32'h40000) - 32'h20000;
            endcase
            push_item(z, start);
            base = base + cfg_offset;
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int set_idx;
        int queued;
        int len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset registers; first step runs on zero state, so the variance is zero
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        push_item(32'hffff_ffff, 1'b0);
        push_item(32'h0001_0000, 1'b1);
        wait_idle();

        // estimate and variance saturate upward; R = 0 gives unit gain
        cfg_all(32'h7fff_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
        push_item(32'h8000_0000, 1'b1);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h1234_5678, 1'b0);
        wait_idle();

        // P and R both zero: prior passes through; estimate saturates downward
        cfg_all(32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
        push_item(32'h7fff_ffff, 1'b1);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'h0000_0000, 1'b0);
        wait_idle();

        // huge R: tiny gain
        cfg_all(32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'hffff_ffff);
        push_item(32'h7fff_ffff, 1'b1);
        push_item(32'h8000_0000, 1'b0);
        push_item(32'hffff_ffff, 1'b0);
        push_item(32'h0000_0000, 1'b1);
        wait_idle();

        // tiny R with large P: gain just below one, negative step
        cfg_all(32'h4000_0000, 32'h7fff_ffff, 32'hffff_0000, 32'h0001_0000, 32'h1);
        push_item(32'h4000_0000, 1'b1);
        push_item(32'hc000_0000, 1'b0);
        push_item(32'h7fff_ffff, 1'b0);
        push_item(32'h8000_0000, 1'b0);
        wait_idle();

        // random part: four back-pressure phases, three register settings each
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (set_idx = 0; set_idx < 3; set_idx++) begin
                cfg_all(pick_word(1'b1), pick_word(1'b0), pick_word(1'b1),
                        pick_word(1'b0), pick_word(1'b0));
                queued = 0;
                while (queued < ITEMS_PER_SET) begin
                    len = $urandom_range(3, 20);
                    add_run(len);
                    queued += len;
                end
                wait_idle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("scalar_kalman_filter_tb: clean");
        else
            $display("scalar_kalman_filter_tb: errors");
        $finish;
    end

endmodule
